// ----- rtl/core/vwm_pkg.sv -----
// Shared types and fixed widths for the vector window mean block.
// No dependencies.
package vwm_pkg;

   localparam int LANES           = 4;
   localparam int SAMPLE_WIDTH    = 16;
   localparam int COUNT_OUT_WIDTH = 4;

   typedef logic signed [SAMPLE_WIDTH-1:0]   sample_type;
   typedef logic [LANES*SAMPLE_WIDTH-1:0]    row_type;
   typedef logic [COUNT_OUT_WIDTH-1:0]       count_out_type;

endpackage

// ----- rtl/core/vwm_req_if.sv -----
// Input channel: valid/ready plus one sample vector word.
// Depends on vwm_pkg.
interface vwm_req_if;
   import vwm_pkg::*;

   logic       valid;
   logic       ready;
   logic       sample_present;
   sample_type lane_value_0;
   sample_type lane_value_1;
   sample_type lane_value_2;
   sample_type lane_value_3;

   modport source (
      output valid, sample_present, lane_value_0, lane_value_1, lane_value_2, lane_value_3,
      input  ready
   );
   modport sink (
      input  valid, sample_present, lane_value_0, lane_value_1, lane_value_2, lane_value_3,
      output ready
   );
endinterface

// ----- rtl/core/vwm_rsp_if.sv -----
// Result channel: valid/ready plus one window mean word.
// Depends on vwm_pkg.
interface vwm_rsp_if;
   import vwm_pkg::*;

   logic          valid;
   logic          ready;
   logic          mean_present;
   sample_type    mean_value_0;
   sample_type    mean_value_1;
   sample_type    mean_value_2;
   sample_type    mean_value_3;
   count_out_type samples_counted;

   modport source (
      output valid, mean_present, mean_value_0, mean_value_1, mean_value_2, mean_value_3,
             samples_counted,
      input  ready
   );
   modport sink (
      input  valid, mean_present, mean_value_0, mean_value_1, mean_value_2, mean_value_3,
             samples_counted,
      output ready
   );
endinterface

// ----- rtl/core/vwm_window_mem.sv -----
// Window sample store: one row of all lanes per slot, registered read.
// Depends on vwm_pkg.
module vwm_window_mem #(
   parameter int DEPTH = 8,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  vwm_pkg::row_type wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output vwm_pkg::row_type rd_data
);
   import vwm_pkg::*;

   row_type mem [DEPTH];
   row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/core/vwm_recip_div.sv -----
// Per-lane signed sum / count, truncated toward zero, by multiplying the
// magnitude with a ceiling reciprocal from a table; one registered stage.
// Depends on vwm_pkg.
module vwm_recip_div #(
   parameter int WINDOW_DEPTH = 8,
   parameter int SW           = vwm_pkg::SAMPLE_WIDTH + $clog2(WINDOW_DEPTH),
   parameter int CW           = $clog2(WINDOW_DEPTH + 1)
) (
   input  logic                clock,
   input  logic                load,
   input  logic signed [SW-1:0] sum_value [vwm_pkg::LANES],
   input  logic [CW-1:0]       count_value,
   output vwm_pkg::sample_type quot [vwm_pkg::LANES]
);
   import vwm_pkg::*;

   // exact floor(n/c) for n < 2^SW, c <= 2^L with m = ceil(2^(SW+L)/c)
   localparam int L  = $clog2(WINDOW_DEPTH);
   localparam int K  = SW + L;
   localparam int MW = K + 1;
   localparam int PW = SW + MW;

   logic [MW-1:0]         recip_tbl [WINDOW_DEPTH+1];
   logic [MW-1:0]         recip_sel;
   logic [SW-1:0]         mag [LANES];
   logic [PW-1:0]         prod_ff [LANES];
   logic                  neg_ff [LANES];
   logic [SAMPLE_WIDTH:0] q [LANES];
   logic [SAMPLE_WIDTH:0] sq [LANES];

   assign recip_tbl[0] = '0;
   for (genvar c = 1; c <= WINDOW_DEPTH; c++) begin : g_recip
      localparam longint unsigned M = ((64'd1 << K) + longint'(c) - 64'd1) / longint'(c);
      assign recip_tbl[c] = MW'(M);
   end

   assign recip_sel = recip_tbl[count_value];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         mag[l] = sum_value[l][SW-1] ? SW'(-sum_value[l]) : SW'(sum_value[l]);
         q[l]   = prod_ff[l][K +: SAMPLE_WIDTH+1];
         sq[l]  = neg_ff[l] ? -q[l] : q[l];
         quot[l] = sample_type'(sq[l][SAMPLE_WIDTH-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int l = 0; l < LANES; l++) begin
            prod_ff[l] <= PW'(mag[l]) * PW'(recip_sel);
            neg_ff[l]  <= sum_value[l][SW-1];
         end
      end
   end
endmodule

// ----- rtl/core/vector_window_mean_with_gaps_top.sv -----
// Vector moving average over a circular window of slots that may be empty.
// Each accepted word takes one slot; every word yields one result word with the
// per-lane mean of the present samples, truncated toward zero. Each item passes
// through accept and window read, running-sum update and write-back, reciprocal
// multiply and result load; the next word is accepted once the result sits in the
// output register, so a stalled result holds the block only after one more item.
// Depends on vwm_pkg, vwm_req_if, vwm_rsp_if, vwm_window_mem, vwm_recip_div.
module vector_window_mean_with_gaps_top #(
   parameter int WINDOW_DEPTH = 8
) (
   input  logic      clock,
   input  logic      reset,
   vwm_req_if.sink   req_port,
   vwm_rsp_if.source rsp_port
);
   import vwm_pkg::*;

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int CW = $clog2(WINDOW_DEPTH + 1);
   localparam int SW = SAMPLE_WIDTH + $clog2(WINDOW_DEPTH);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_MUL  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [AW-1:0]           ptr_ff, ptr_in;
   logic [WINDOW_DEPTH-1:0] present_ff, present_in;
   logic [CW-1:0]           count_ff, count_in;
   logic signed [SW-1:0]    sum_ff [LANES];
   logic signed [SW-1:0]    sum_in [LANES];
   logic                    old_present_ff;
   logic                    in_present_ff;
   sample_type              in_value_ff [LANES];
   sample_type              old_value [LANES];
   row_type                 wr_row, rd_row;
   sample_type              quot [LANES];
   logic                    accept;
   logic                    load_out;

   logic                    rsp_valid_ff;
   logic                    rsp_present_ff;
   sample_type              rsp_mean_ff [LANES];
   count_out_type           rsp_count_ff;

   assign accept   = req_port.valid && req_port.ready;
   assign req_port.ready = (state_ff == S_IDLE);
   assign load_out = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_port.ready);

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         wr_row[l*SAMPLE_WIDTH +: SAMPLE_WIDTH] = in_value_ff[l];
         old_value[l] = sample_type'(rd_row[l*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
      end
   end

   // slot write happens in S_READ, next read only after the next accept
   vwm_window_mem #(.DEPTH(WINDOW_DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   ((state_ff == S_READ) && in_present_ff),
      .wr_addr (ptr_ff),
      .wr_data (wr_row),
      .rd_en   (accept),
      .rd_addr (ptr_ff),
      .rd_data (rd_row)
   );

   vwm_recip_div #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_div (
      .clock       (clock),
      .load        (state_ff == S_MUL),
      .sum_value   (sum_ff),
      .count_value (count_ff),
      .quot        (quot)
   );

   always_comb begin
      state_in   = state_ff;
      ptr_in     = ptr_ff;
      present_in = present_ff;
      count_in   = count_ff;
      for (int l = 0; l < LANES; l++) begin
         sum_in[l] = sum_ff[l];
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            for (int l = 0; l < LANES; l++) begin
               sum_in[l] = sum_ff[l]
                         - (old_present_ff ? SW'(old_value[l]) : SW'(0))
                         + (in_present_ff ? SW'(in_value_ff[l]) : SW'(0));
            end
            count_in = count_ff - CW'(old_present_ff) + CW'(in_present_ff);
            present_in[ptr_ff] = in_present_ff;
            ptr_in   = (ptr_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : ptr_ff + AW'(1);
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ptr_ff     <= '0;
         present_ff <= '0;
         count_ff   <= '0;
         for (int l = 0; l < LANES; l++) begin
            sum_ff[l] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         ptr_ff     <= ptr_in;
         present_ff <= present_in;
         count_ff   <= count_in;
         for (int l = 0; l < LANES; l++) begin
            sum_ff[l] <= sum_in[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         old_present_ff <= present_ff[ptr_ff];
         in_present_ff  <= req_port.sample_present;
         in_value_ff[0] <= req_port.lane_value_0;
         in_value_ff[1] <= req_port.lane_value_1;
         in_value_ff[2] <= req_port.lane_value_2;
         in_value_ff[3] <= req_port.lane_value_3;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_present_ff <= (count_ff != '0);
         rsp_count_ff   <= count_out_type'(count_ff);
         for (int l = 0; l < LANES; l++) begin
            rsp_mean_ff[l] <= (count_ff != '0) ? quot[l] : '0;
         end
      end
   end

   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.mean_present    = rsp_present_ff;
   assign rsp_port.mean_value_0    = rsp_mean_ff[0];
   assign rsp_port.mean_value_1    = rsp_mean_ff[1];
   assign rsp_port.mean_value_2    = rsp_mean_ff[2];
   assign rsp_port.mean_value_3    = rsp_mean_ff[3];
   assign rsp_port.samples_counted = rsp_count_ff;

   a_count_matches_slots: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) == $countones(present_ff))
      else $error("present count differs from slot flags");

   a_result_after_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result word loaded outside result state");

   a_absent_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_present_ff |->
         rsp_mean_ff[0] == '0 && rsp_mean_ff[1] == '0 &&
         rsp_mean_ff[2] == '0 && rsp_mean_ff[3] == '0)
      else $error("empty window result carries nonzero mean");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for vector_window_mean_with_gaps_top: sends sample words with gaps and
// back-pressure, predicts every window mean and checks each result word in order.
// Depends on vwm_pkg, vwm_req_if, vwm_rsp_if and the RTL under rtl/core.
module testbench;
   import vwm_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int WINDOW_DEPTH = 8;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int MAX_REPORTS  = 40;

   typedef struct {
      logic       present;
      sample_type lane [LANES];
   } sample_word_type;

   typedef struct {
      logic          present;
      sample_type    mean [LANES];
      count_out_type counted;
   } mean_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vwm_req_if req_bus ();
   vwm_rsp_if rsp_bus ();

   vector_window_mean_with_gaps_top #(.WINDOW_DEPTH(WINDOW_DEPTH)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // window predictor
   sample_type    window_lane [WINDOW_DEPTH][LANES];
   logic          window_full [WINDOW_DEPTH];
   int unsigned   window_slot;
   int            lane_sum [LANES];
   int            full_slots;
   mean_word_type expected_means [$];

   int unsigned cycle_count   = 0;
   int unsigned error_count   = 0;
   int unsigned words_sent    = 0;
   int unsigned absent_sent   = 0;
   int unsigned results_seen  = 0;
   int unsigned empty_windows = 0;
   int unsigned full_windows  = 0;
   int unsigned input_stalls  = 0;

   // receiver controls
   int unsigned stall_pct    = 0;
   int unsigned hold_request = 0;
   int unsigned hold_left    = 0;

   function automatic void clear_window();
      for (int s = 0; s < WINDOW_DEPTH; s++) begin
         window_full[s] = 1'b0;
         for (int l = 0; l < LANES; l++) window_lane[s][l] = '0;
      end
      for (int l = 0; l < LANES; l++) lane_sum[l] = 0;
      window_slot = 0;
      full_slots  = 0;
   endfunction

   function automatic mean_word_type slide_window(input sample_word_type word);
      mean_word_type result;
      if (window_full[window_slot]) begin
         for (int l = 0; l < LANES; l++) lane_sum[l] -= window_lane[window_slot][l];
         full_slots--;
      end
      if (word.present) begin
         for (int l = 0; l < LANES; l++) begin
            window_lane[window_slot][l] = word.lane[l];
            lane_sum[l] += word.lane[l];
         end
         full_slots++;
      end
      window_full[window_slot] = word.present;
      window_slot = (window_slot + 1) % WINDOW_DEPTH;
      result.present = (full_slots != 0);
      result.counted = count_out_type'(full_slots);
      // int division truncates toward zero
      for (int l = 0; l < LANES; l++)
         result.mean[l] = (full_slots == 0) ? '0 : sample_type'(lane_sum[l] / full_slots);
      return result;
   endfunction

   function automatic sample_word_type make_word(input logic present, input sample_type v0,
                                                 input sample_type v1, input sample_type v2,
                                                 input sample_type v3);
      sample_word_type word;
      word.present = present;
      word.lane[0] = v0;
      word.lane[1] = v1;
      word.lane[2] = v2;
      word.lane[3] = v3;
      return word;
   endfunction

   function automatic sample_type pick_lane(input int unsigned extreme_pct);
      sample_type pick;
      if ($urandom_range(0, 99) < extreme_pct) begin
         case ($urandom_range(0, 4))
            0: pick = 16'sh7FFF;
            1: pick = 16'sh8000;
            2: pick = 16'sh0000;
            3: pick = 16'sh0001;
            default: pick = 16'shFFFF;
         endcase
      end else begin
         pick = sample_type'($urandom);
      end
      return pick;
   endfunction

   function automatic sample_word_type random_word(input int unsigned present_pct,
                                                   input int unsigned extreme_pct);
      return make_word($urandom_range(0, 99) < present_pct, pick_lane(extreme_pct),
                       pick_lane(extreme_pct), pick_lane(extreme_pct),
                       pick_lane(extreme_pct));
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("MISMATCH cycle %0d: %s", cycle_count, what);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s got %h want %h", results_seen, name,
                                   got, want));
   endtask

   // called at a falling edge, returns at a falling edge; valid stays high
   task automatic send_sample(input sample_word_type word);
      req_bus.valid          <= 1'b1;
      req_bus.sample_present <= word.present;
      req_bus.lane_value_0   <= word.lane[0];
      req_bus.lane_value_1   <= word.lane[1];
      req_bus.lane_value_2   <= word.lane[2];
      req_bus.lane_value_3   <= word.lane[3];
      @(posedge clock);
      while (req_bus.ready !== 1'b1) begin
         input_stalls++;
         @(posedge clock);
      end
      expected_means.push_back(slide_window(word));
      words_sent++;
      if (!word.present) absent_sent++;
      @(negedge clock);
   endtask

   task automatic pause_input(input int unsigned cycles);
      if (cycles != 0) begin
         req_bus.valid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   task automatic send_random_words(input int count, input int unsigned present_pct,
                                    input int unsigned extreme_pct,
                                    input int unsigned max_gap);
      int left;
      int burst;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 16);
         if (burst > left) burst = left;
         repeat (burst) send_sample(random_word(present_pct, extreme_pct));
         left -= burst;
         pause_input($urandom_range(0, max_gap));
      end
   endtask

   // empty window after reset, absent slots, lane extremes, truncation of negative means
   task automatic test_directed_window();
      stall_pct = 0;
      send_sample(make_word(1'b0, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
      send_sample(make_word(1'b1, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001));
      send_sample(make_word(1'b1, 16'sh8000, 16'sh7FFF, 16'shFFFF, 16'sh0000));
      send_sample(make_word(1'b0, 16'sh1234, 16'shA5A5, 16'sh7FFF, 16'sh8000));
      repeat (8) send_sample(make_word(1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
      repeat (3) send_sample(make_word(1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
      repeat (8) send_sample(make_word(1'b0, 16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh5A5A));
      pause_input(1);
   endtask

   task automatic test_random_density();
      stall_pct = 20;
      send_random_words(250, 90, 10, 3);
      stall_pct = 40;
      send_random_words(250, 50, 10, 6);
      stall_pct = 30;
      send_random_words(200, 15, 20, 4);
      stall_pct = 10;
      send_random_words(20, 0, 0, 2);
      stall_pct = 0;
      send_random_words(60, 100, 0, 0);
   endtask

   task automatic test_extreme_values();
      stall_pct = 25;
      send_random_words(100, 100, 90, 2);
      send_random_words(100, 80, 90, 3);
   endtask

   task automatic test_backpressure_hold();
      stall_pct    = 0;
      hold_request = 300;
      repeat (40) send_sample(random_word(85, 30));
      pause_input(1);
   endtask

   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      mean_word_type want;
      if (!reset && $isunknown(rsp_bus.valid))
         report_mismatch("result valid is unknown");
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         results_seen++;
         if (expected_means.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
         end else begin
            want = expected_means.pop_front();
            if (!want.present) empty_windows++;
            if (want.counted == WINDOW_DEPTH) full_windows++;
            check_field("mean_present", 16'(rsp_bus.mean_present), 16'(want.present));
            check_field("mean_value_0", rsp_bus.mean_value_0, want.mean[0]);
            check_field("mean_value_1", rsp_bus.mean_value_1, want.mean[1]);
            check_field("mean_value_2", rsp_bus.mean_value_2, want.mean[2]);
            check_field("mean_value_3", rsp_bus.mean_value_3, want.mean[3]);
            check_field("samples_counted", 16'(rsp_bus.samples_counted),
                        16'(want.counted));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_means.size());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int unsigned drain_cycles;
      req_bus.valid          = 1'b0;
      req_bus.sample_present = 1'b0;
      req_bus.lane_value_0   = '0;
      req_bus.lane_value_1   = '0;
      req_bus.lane_value_2   = '0;
      req_bus.lane_value_3   = '0;
      clear_window();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_window();
      test_random_density();
      test_extreme_values();
      test_backpressure_hold();

      stall_pct    = 0;
      drain_cycles = 0;
      while (expected_means.size() != 0 && drain_cycles < 2000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (16) @(posedge clock);
      if (expected_means.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_means.size()));

      $display("Sent %0d sample words (%0d empty slots), checked %0d result words",
               words_sent, absent_sent, results_seen);
      $display("Windows seen empty %0d times and full %0d times; input held %0d cycles",
               empty_windows, full_windows, input_stalls);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", error_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
